### design/sqd_pkg.sv
`timescale 1ns / 1ps

// Shared codes and the command word that passes from the front to the back.
package sqd_pkg;

   // Field widths fixed by the stream words.
   localparam int OP_W      = 3;
   localparam int ITEM_ID_W = 8;
   localparam int QINDEX_W  = 6;
   localparam int STATUS_W  = 2;
   localparam int LIMIT_W   = 4;

   // Operation codes as they arrive on the request channel.
   localparam logic [OP_W-1:0] OP_ENQUEUE     = 3'd0;
   localparam logic [OP_W-1:0] OP_DEQUEUE     = 3'd1;
   localparam logic [OP_W-1:0] OP_BLOCK       = 3'd2;
   localparam logic [OP_W-1:0] OP_UNBLOCK_ALL = 3'd3;
   localparam logic [OP_W-1:0] OP_MIGRATE     = 3'd4;

   // Response status codes.
   localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   // Queue limit after reset.
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd5;

   // Decoded command kind.
   typedef enum logic [2:0] {
      KIND_NOP,
      KIND_ENQUEUE,
      KIND_DEQUEUE,
      KIND_BLOCK,
      KIND_UNBLOCK_ALL,
      KIND_MIGRATE
   } kind_type;

   // One classified command as it waits in the command queue.
   typedef struct packed {
      kind_type              kind;
      logic [ITEM_ID_W-1:0]  item;
      logic [QINDEX_W-1:0]   qindex;
      logic                  qindex_ok;
   } cmd_type;

endpackage

### design/sqd_front.sv
`timescale 1ns / 1ps

// Accepts request words, classifies them and holds them in a two-entry queue.
module sqd_front import sqd_pkg::*; #(
   parameter int NUM_QUEUES = 64
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [15:0]   req_tdata,   // item_id [7:0], queue_index [13:8], zero [15:14]
   input  logic [7:0]    req_tuser,   // operation [2:0], zero [7:3]
   output logic          cmd_valid,
   output cmd_type       cmd_head,
   input  logic          cmd_pop
);

   localparam int CMDQ_DEPTH = 2;

   cmd_type             new_cmd;
   cmd_type             slot_ff [CMDQ_DEPTH];
   logic                wr_ptr_ff, wr_ptr_in;
   logic                rd_ptr_ff, rd_ptr_in;
   logic [1:0]          count_ff, count_in;
   logic                push;

   // Decode the operation and check the addressed queue against the queue count.
   always_comb begin
      new_cmd.item      = req_tdata[ITEM_ID_W-1:0];
      new_cmd.qindex    = req_tdata[ITEM_ID_W +: QINDEX_W];
      new_cmd.qindex_ok = 32'(req_tdata[ITEM_ID_W +: QINDEX_W]) < NUM_QUEUES;
      unique case (req_tuser[OP_W-1:0])
         OP_ENQUEUE:     new_cmd.kind = KIND_ENQUEUE;
         OP_DEQUEUE:     new_cmd.kind = KIND_DEQUEUE;
         OP_BLOCK:       new_cmd.kind = KIND_BLOCK;
         OP_UNBLOCK_ALL: new_cmd.kind = KIND_UNBLOCK_ALL;
         OP_MIGRATE:     new_cmd.kind = KIND_MIGRATE;
         default:        new_cmd.kind = KIND_NOP;
      endcase
   end

   // Queue handshake and pointers.
   assign req_tready = count_ff != 2'(CMDQ_DEPTH);
   assign push       = req_tvalid && req_tready;
   assign cmd_valid  = count_ff != 2'd0;
   assign cmd_head   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue entries carry payload only.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

### design/sqd_back.sv
`timescale 1ns / 1ps

// Carries out each command as a launch cycle that searches groups of
// queues and reads the source head, and an execute cycle that finishes the
// search, updates the queue state and loads the response register.
module sqd_back import sqd_pkg::*; #(
   parameter int NUM_QUEUES  = 64,
   parameter int QUEUE_DEPTH = 8,
   parameter int ITEM_WIDTH  = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [LIMIT_W-1:0]   csr_wdata,
   input  logic                 cmd_valid,
   input  cmd_type              cmd_head,
   output logic                 cmd_pop,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [15:0]          rsp_tdata,   // chosen_queue [5:0], item_out [13:6],
                                             // all_empty [14], zero [15]
   output logic [7:0]           rsp_tuser    // status [1:0], zero [7:2]
);

   localparam int QW      = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
   localparam int HW      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int LW      = $clog2(QUEUE_DEPTH + 1);
   localparam int SW      = $clog2(2 * QUEUE_DEPTH);
   localparam int ENTRIES = NUM_QUEUES * QUEUE_DEPTH;
   localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int TW      = $clog2(ENTRIES + 1);
   localparam int GROUP   = 8;
   localparam int NG      = (NUM_QUEUES + GROUP - 1) / GROUP;
   localparam int NGP     = 1 << $clog2(NG);
   localparam int NP      = NG * GROUP;
   localparam int KW      = 1 + LW + QW;
   localparam logic [KW-1:0] KEY_NONE = '1;

   typedef enum logic [1:0] {
      ST_LAUNCH = 2'b01,
      ST_EXEC   = 2'b10
   } state_type;

   state_type               state_ff, state_in;
   logic [LIMIT_W-1:0]      limit_ff;
   logic [HW-1:0]           head_ff [NUM_QUEUES];
   logic [HW-1:0]           head_in [NUM_QUEUES];
   logic [LW-1:0]           len_ff [NUM_QUEUES];
   logic [LW-1:0]           len_in [NUM_QUEUES];
   logic [NUM_QUEUES-1:0]   blocked_ff, blocked_in;
   logic [TW-1:0]           total_ff, total_in;

   cmd_type                 cmd_ff;
   logic                    src_empty_ff, src_empty_in;
   logic [KW-1:0]           grp_key_ff [NG];
   logic [KW-1:0]           grp_key_in [NG];

   logic [ITEM_WIDTH-1:0]   store [ENTRIES];
   logic [ITEM_WIDTH-1:0]   rdata_ff;
   logic                    mem_we;
   logic [AW-1:0]           mem_waddr, mem_raddr;
   logic [ITEM_WIDTH-1:0]   mem_wdata;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]     rsp_status_ff, rsp_status_in;
   logic [QINDEX_W-1:0]     rsp_chosen_ff, rsp_chosen_in;
   logic [ITEM_ID_W-1:0]    rsp_item_ff, rsp_item_in;
   logic                    rsp_empty_ff, rsp_empty_in;

   logic                    launch, exec;
   logic [LW-1:0]           eff_lim;
   logic [QW-1:0]           src_q, ex_q, tgt;
   logic [KW-1:0]           best_key;
   logic                    tgt_none;
   logic [HW-1:0]           tgt_head, src_head;
   logic [LW-1:0]           tgt_len, src_len;
   logic [SW-1:0]           tail_sum;
   logic [HW-1:0]           tail_slot, front_slot, pop_slot;
   logic [AW-1:0]           tgt_base;

   assign launch  = (state_ff == ST_LAUNCH) && cmd_valid && (!rsp_valid_ff || rsp_tready);
   assign exec    = state_ff == ST_EXEC;
   assign cmd_pop = launch;

   // A limit above the queue depth acts as the depth.
   assign eff_lim = (32'(limit_ff) > QUEUE_DEPTH) ? LW'(QUEUE_DEPTH) : LW'(limit_ff);

   // Launch: source queue, its emptiness and the read of its head item.
   assign src_q        = cmd_head.qindex_ok ? QW'(cmd_head.qindex) : '0;
   assign src_empty_in = !cmd_head.qindex_ok || (len_ff[src_q] == '0);
   assign mem_raddr    = AW'(src_q) * AW'(QUEUE_DEPTH) + AW'(head_ff[src_q]);

   // Launch: first tree level, the best candidate in each group of eight queues.
   // A key orders by eligibility, then length, then index for the lowest-index tie.
   always_comb begin
      logic [KW-1:0] leaf [NP];
      logic [KW-1:0] red  [GROUP];
      for (int q = 0; q < NP; q++) begin
         leaf[q] = KEY_NONE;
      end
      for (int q = 0; q < NUM_QUEUES; q++) begin
         if (!blocked_ff[q] && (len_ff[q] < eff_lim) &&
             !((cmd_head.kind == KIND_MIGRATE) && (QW'(q) == src_q))) begin
            leaf[q] = {1'b0, len_ff[q], QW'(q)};
         end
      end
      for (int g = 0; g < NG; g++) begin
         for (int i = 0; i < GROUP; i++) begin
            red[i] = leaf[g * GROUP + i];
         end
         for (int s = 1; s < GROUP; s = s * 2) begin
            for (int i = 0; i + s < GROUP; i = i + 2 * s) begin
               if (red[i + s] < red[i]) begin
                  red[i] = red[i + s];
               end
            end
         end
         grp_key_in[g] = red[0];
      end
   end

   // Execute: second tree level over the registered group winners.
   always_comb begin
      logic [KW-1:0] fin [NGP];
      for (int i = 0; i < NGP; i++) begin
         fin[i] = KEY_NONE;
      end
      for (int i = 0; i < NG; i++) begin
         fin[i] = grp_key_ff[i];
      end
      for (int s = 1; s < NGP; s = s * 2) begin
         for (int i = 0; i + s < NGP; i = i + 2 * s) begin
            if (fin[i + s] < fin[i]) begin
               fin[i] = fin[i + s];
            end
         end
      end
      best_key = fin[0];
   end

   assign tgt_none = best_key[KW-1];
   assign tgt      = tgt_none ? '0 : best_key[QW-1:0];
   assign ex_q     = cmd_ff.qindex_ok ? QW'(cmd_ff.qindex) : '0;
   assign tgt_head = head_ff[tgt];
   assign tgt_len  = len_ff[tgt];
   assign src_head = head_ff[ex_q];
   assign src_len  = len_ff[ex_q];
   assign tgt_base = AW'(tgt) * AW'(QUEUE_DEPTH);

   // Ring arithmetic on slot numbers; every sum stays below twice the depth.
   always_comb begin
      tail_sum   = SW'(tgt_head) + SW'(tgt_len);
      tail_slot  = (tail_sum >= SW'(QUEUE_DEPTH)) ? HW'(tail_sum - SW'(QUEUE_DEPTH))
                                                  : HW'(tail_sum);
      front_slot = (tgt_head == '0) ? HW'(QUEUE_DEPTH - 1) : tgt_head - 1'b1;
      pop_slot   = (src_head == HW'(QUEUE_DEPTH - 1)) ? '0 : src_head + 1'b1;
   end

   // Execute: apply the command to the queue state and form the response.
   always_comb begin
      head_in       = head_ff;
      len_in        = len_ff;
      blocked_in    = blocked_ff;
      total_in      = total_ff;
      mem_we        = 1'b0;
      mem_waddr     = tgt_base + AW'(tail_slot);
      mem_wdata     = ITEM_WIDTH'(32'(cmd_ff.item));
      rsp_status_in = STATUS_DONE;
      rsp_chosen_in = cmd_ff.qindex;
      rsp_item_in   = '0;
      if (exec) begin
         unique case (cmd_ff.kind)
            KIND_ENQUEUE: begin
               if (tgt_none) begin
                  rsp_status_in = STATUS_FULL;
                  rsp_chosen_in = '0;
               end else begin
                  mem_we        = 1'b1;
                  len_in[tgt]   = tgt_len + 1'b1;
                  total_in      = total_ff + 1'b1;
                  rsp_chosen_in = QINDEX_W'(tgt);
               end
            end
            KIND_DEQUEUE: begin
               if (src_empty_ff) begin
                  rsp_status_in = STATUS_EMPTY;
               end else begin
                  head_in[ex_q] = pop_slot;
                  len_in[ex_q]  = src_len - 1'b1;
                  total_in      = total_ff - 1'b1;
                  rsp_item_in   = ITEM_ID_W'(rdata_ff);
               end
            end
            KIND_BLOCK: begin
               if (cmd_ff.qindex_ok) begin
                  blocked_in[ex_q] = 1'b1;
               end
            end
            KIND_UNBLOCK_ALL: begin
               blocked_in = '0;
            end
            KIND_MIGRATE: begin
               if (src_empty_ff) begin
                  rsp_status_in = STATUS_EMPTY;
               end else if (tgt_none) begin
                  rsp_status_in = STATUS_FULL;
               end else begin
                  // Pop the source head and push it at the front of the target.
                  head_in[ex_q] = pop_slot;
                  len_in[ex_q]  = src_len - 1'b1;
                  head_in[tgt]  = front_slot;
                  len_in[tgt]   = tgt_len + 1'b1;
                  mem_we        = 1'b1;
                  mem_waddr     = tgt_base + AW'(front_slot);
                  mem_wdata     = rdata_ff;
                  rsp_chosen_in = QINDEX_W'(tgt);
                  rsp_item_in   = ITEM_ID_W'(rdata_ff);
               end
            end
            default: begin
            end
         endcase
      end
      rsp_empty_in = total_in == '0;
   end

   // Sequencer and response valid.
   always_comb begin
      unique case (state_ff)
         ST_LAUNCH: state_in = launch ? ST_EXEC : ST_LAUNCH;
         ST_EXEC:   state_in = ST_LAUNCH;
         default:   state_in = ST_LAUNCH;
      endcase
      if (exec) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control and queue bookkeeping registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LAUNCH;
         limit_ff     <= LIMIT_RESET;
         blocked_ff   <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int q = 0; q < NUM_QUEUES; q++) begin
            head_ff[q] <= '0;
            len_ff[q]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         blocked_ff   <= blocked_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
         head_ff      <= head_in;
         len_ff       <= len_in;
         if (csr_we) begin
            limit_ff <= csr_wdata;
         end
      end
   end

   // Payload registers between launch and execute, and of the response.
   always_ff @(posedge clock) begin
      if (launch) begin
         cmd_ff       <= cmd_head;
         src_empty_ff <= src_empty_in;
         grp_key_ff   <= grp_key_in;
      end
      if (exec) begin
         rsp_status_ff <= rsp_status_in;
         rsp_chosen_ff <= rsp_chosen_in;
         rsp_item_ff   <= rsp_item_in;
         rsp_empty_ff  <= rsp_empty_in;
      end
   end

   // Item store: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store[mem_waddr] <= mem_wdata;
      end
      if (launch) begin
         rdata_ff <= store[mem_raddr];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_empty_ff, rsp_item_ff, rsp_chosen_ff};
   assign rsp_tuser  = {6'b0, rsp_status_ff};

endmodule

### design/shortest_queue_dispatcher_top.sv
`timescale 1ns / 1ps

// Channel   Direction  Word fields (low bit first)
// req_      in         tuser: operation; tdata: item_id, queue_index
// rsp_      out        tuser: status; tdata: chosen_queue, item_out, all_empty
// csr_      in         wdata: queue_limit, written when csr_we is high
//
// In the back end each command has a launch cycle that ranks the
// queues in groups of eight and reads the source head from the item store, and
// an execute cycle that ranks the group winners and writes the queue state.
// A response follows its request word through the command queue, launch and execute.
// Reset clears lengths, heads, blocked flags and the item count, and sets the
// limit to five; the item store is not cleared and needs no clearing pass.
// A two-word command queue lets requests arrive while the response register
// waits on rsp_tready; a new command launches as the held response is taken.
module shortest_queue_dispatcher_top import sqd_pkg::*; #(
   parameter int NUM_QUEUES  = 64,
   parameter int QUEUE_DEPTH = 8,
   parameter int ITEM_WIDTH  = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [LIMIT_W-1:0]   csr_wdata,   // queue_limit [3:0]
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [15:0]          req_tdata,   // item_id [7:0], queue_index [13:8], zero [15:14]
   input  logic [7:0]           req_tuser,   // operation [2:0], zero [7:3]
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [15:0]          rsp_tdata,   // chosen_queue [5:0], item_out [13:6],
                                             // all_empty [14], zero [15]
   output logic [7:0]           rsp_tuser    // status [1:0], zero [7:2]
);

   logic      cmd_valid;
   cmd_type   cmd_head;
   logic      cmd_pop;

   sqd_front #(
      .NUM_QUEUES (NUM_QUEUES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd_valid  (cmd_valid),
      .cmd_head   (cmd_head),
      .cmd_pop    (cmd_pop)
   );

   sqd_back #(
      .NUM_QUEUES  (NUM_QUEUES),
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .ITEM_WIDTH  (ITEM_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .cmd_valid  (cmd_valid),
      .cmd_head   (cmd_head),
      .cmd_pop    (cmd_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

`ifndef SYNTHESIS
   // The back end only takes a command the front end holds.
   a_pop_has_cmd: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cmd_valid)
      else $error("command taken from an empty command queue");

   // One command at a time: a launch is always followed by an execute cycle.
   a_pop_spacing: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |=> !cmd_pop)
      else $error("two commands launched in back-to-back cycles");

   // A fresh response comes from a command that was launched and then executed.
   a_rsp_from_cmd: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(cmd_pop, 2))
      else $error("response word without a launched command");

   // A failed command never reports a moved or popped item.
   a_fail_no_item: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && ((rsp_tuser[1:0] == STATUS_FULL) || (rsp_tuser[1:0] == STATUS_EMPTY))
      |-> (rsp_tdata[13:6] == 8'd0))
      else $error("failed command reports an item");
`endif

endmodule
